FILE: src/hhq_pkg.sv
// ----------------------------------------------------------------------------
// hhq_pkg
// Shared types and constants for the hash history queue.
// ----------------------------------------------------------------------------
package hhq_pkg;

    localparam int KEY_W         = 64;
    localparam int COUNT_W       = 7;
    localparam int LIMIT_W       = 6;
    localparam int CMD_W         = 2;
    localparam int DEPTH_DEFAULT = 64;
    localparam int OUT_TDATA_W   = 72;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;

    localparam logic [CMD_W-1:0] CMD_ADD            = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ONE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_THROUGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               found;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

FILE: src/hash_history_queue.sv
// ----------------------------------------------------------------------------
// hash_history_queue
// Ordered history of 64-bit message hashes, oldest first, with add,
// remove-one and remove-through-first-match commands.
// ----------------------------------------------------------------------------
//  Channel   Dir  Ports                 Contents
//  s_axis    in   tdata[63:0]           key
//                 tuser[1:0]            command
//  m_axis    out  tdata[63:0]           key_out
//                 tdata[70:64]          count (bit 71 is zero)
//                 tuser[0]              found
//  cfg       in   cfg_data[5:0]         history_limit
//
// An add or unused command goes from acceptance straight to the finish state, which offers the result.
// A remove scans the store one RAM read per cycle up to the first match, then
// a remove-one closes the gap by moving each later entry down one place, one
// entry per cycle. A new command is taken while the previous result waits in
// the output register. The entry RAM needs no clearing; the block is ready
// right after reset, which clears the count and head pointer and sets the
// limit to 63.
// ----------------------------------------------------------------------------
module hash_history_queue #(
    parameter int DEPTH = hhq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hhq_pkg::KEY_W-1:0]         s_axis_tdata,  // key
    input  logic [hhq_pkg::CMD_W-1:0]         s_axis_tuser,  // command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hhq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // key_out, count, zero pad
    output logic [0:0]                        m_axis_tuser,  // found
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hhq_pkg::LIMIT_W-1:0]       cfg_data       // history_limit
);

    localparam int AW = $clog2(DEPTH);

    logic                        res_valid;
    logic                        res_ready;
    hhq_pkg::result_t            res;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [hhq_pkg::KEY_W-1:0]   ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [hhq_pkg::KEY_W-1:0]   ram_rdata;

    hhq_ram #(
        .WIDTH (hhq_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hhq_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_key    (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    hhq_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: src/hhq_ram.sv
// ----------------------------------------------------------------------------
// hhq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hhq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/hhq_engine.sv
// ----------------------------------------------------------------------------
// hhq_engine
// Command sequencer: circular buffer pointers, linear search and compaction
// sweep over the entry RAM, and the history limit register.
// ----------------------------------------------------------------------------
module hhq_engine #(
    parameter int DEPTH = hhq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hhq_pkg::LIMIT_W-1:0]     cfg_data,
    // Command input
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hhq_pkg::CMD_W-1:0]       in_cmd,
    input  logic [hhq_pkg::KEY_W-1:0]       in_key,
    // Result toward the output stage
    output logic                            res_valid,
    input  logic                            res_ready,
    output hhq_pkg::result_t                res,
    // Entry RAM
    output logic                            ram_we,
    output logic [$clog2(DEPTH)-1:0]        ram_waddr,
    output logic [hhq_pkg::KEY_W-1:0]       ram_wdata,
    output logic                            ram_re,
    output logic [$clog2(DEPTH)-1:0]        ram_raddr,
    input  logic [hhq_pkg::KEY_W-1:0]       ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    hhq_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                 head_reg, head_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [hhq_pkg::LIMIT_W-1:0]   limit_reg;
    logic [hhq_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [hhq_pkg::KEY_W-1:0]     key_reg, key_next;
    logic                          found_reg, found_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic [CW-1:0]                 cmp_idx_reg, cmp_idx_next;
    logic                          pend_reg, pend_next;

    logic in_fire;
    logic issue;
    logic hit;
    logic evict;
    logic shift_more;

    // Logical position to physical RAM address, modulo the depth.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == hhq_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign issue     = (idx_reg < cnt_reg);
    assign hit       = pend_reg && (ram_rdata == key_reg);
    assign evict     = (32'(cnt_reg) > 32'(limit_reg)) || (cnt_reg == CNT_FULL);
    assign shift_more = (cmp_idx_reg + CNT_ONE) < cnt_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hhq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == hhq_pkg::CMD_REMOVE_ONE ||
                        in_cmd == hhq_pkg::CMD_REMOVE_THROUGH)
                    begin
                        state_next = hhq_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = hhq_pkg::ST_FINISH;
                    end
                end
            end
            hhq_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    if (cmd_reg == hhq_pkg::CMD_REMOVE_ONE && shift_more)
                    begin
                        state_next = hhq_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = hhq_pkg::ST_FINISH;
                    end
                end
                else if (!pend_reg && !issue)
                begin
                    state_next = hhq_pkg::ST_FINISH;
                end
            end
            hhq_pkg::ST_SHIFT:
            begin
                if (!pend_reg && !issue)
                begin
                    state_next = hhq_pkg::ST_FINISH;
                end
            end
            hhq_pkg::ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = hhq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hhq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        found_next   = found_reg;
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = phys(head_reg, cnt_reg);
        ram_wdata    = in_key;
        ram_re       = 1'b0;
        ram_raddr    = phys(head_reg, idx_reg);
        res_valid    = 1'b0;
        case (state_reg)
            hhq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = in_cmd;
                    key_next   = in_key;
                    found_next = 1'b0;
                    idx_next   = '0;
                    if (in_cmd == hhq_pkg::CMD_ADD)
                    begin
                        // With an eviction the new tail lands on the old head
                        // plus the old count, so the address is the same.
                        ram_we = 1'b1;
                        if (evict)
                        begin
                            head_next = phys(head_reg, CNT_ONE);
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CNT_ONE;
                        end
                    end
                end
            end
            hhq_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    if (cmd_reg == hhq_pkg::CMD_REMOVE_THROUGH)
                    begin
                        head_next = phys(head_reg, cmp_idx_reg + CNT_ONE);
                        cnt_next  = cnt_reg - (cmp_idx_reg + CNT_ONE);
                    end
                    else if (shift_more)
                    begin
                        idx_next = cmp_idx_reg + CNT_ONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_ONE;
                    end
                end
                else if (issue)
                begin
                    ram_re       = 1'b1;
                    idx_next     = idx_reg + CNT_ONE;
                    cmp_idx_next = idx_reg;
                    pend_next    = 1'b1;
                end
            end
            hhq_pkg::ST_SHIFT:
            begin
                // Read entry idx while the entry read last cycle moves down one.
                if (issue)
                begin
                    ram_re       = 1'b1;
                    idx_next     = idx_reg + CNT_ONE;
                    cmp_idx_next = idx_reg;
                    pend_next    = 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(head_reg, cmp_idx_reg - CNT_ONE);
                    ram_wdata = ram_rdata;
                end
                if (!pend_reg && !issue)
                begin
                    cnt_next = cnt_reg - CNT_ONE;
                end
            end
            hhq_pkg::ST_FINISH:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    assign res.found = found_reg;
    assign res.key   = key_reg;
    assign res.count = hhq_pkg::COUNT_W'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hhq_pkg::ST_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
            limit_reg <= hhq_pkg::LIMIT_RESET;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("entry count exceeds the depth");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("compaction writes the entry it is reading");

    a_add_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hhq_pkg::ST_FINISH && found_reg) |->
        (cmd_reg == hhq_pkg::CMD_REMOVE_ONE || cmd_reg == hhq_pkg::CMD_REMOVE_THROUGH))
        else $error("found reported for a command that does not remove");

    a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hhq_pkg::ST_FINISH && cmd_reg == hhq_pkg::CMD_ADD) |->
        (cnt_reg != '0))
        else $error("store empty after an add");

    // A remove-one that still has entries to move shrinks the count only
    // once the compaction sweep has finished.
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hhq_pkg::ST_SEARCH && hit &&
         (cmd_reg == hhq_pkg::CMD_REMOVE_THROUGH || !shift_more))
        |=> (cnt_reg < $past(cnt_reg)))
        else $error("a removal left the count unchanged");

endmodule

FILE: src/hhq_out_stage.sv
// ----------------------------------------------------------------------------
// hhq_out_stage
// Output register: holds one result transaction and packs it for the stream.
// ----------------------------------------------------------------------------
module hhq_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              res_valid,
    output logic                              res_ready,
    input  hhq_pkg::result_t                  res,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hhq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [0:0]                        m_axis_tuser
);

    logic             valid_reg;
    hhq_pkg::result_t data_reg;

    // A new result may load whenever the register is empty or draining.
    assign res_ready = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, data_reg.count, data_reg.key};
    assign m_axis_tuser  = data_reg.found;

endmodule

FILE: sim/tb_hash_history_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_history_queue
// Self-checking bench for the hash history queue. A short table of directed
// commands runs first, then a fill past the depth, then phases of random
// commands under several history limits. A behavioral copy of the history
// predicts each untyped result, typed table rows carry their own, and every
// output transaction is checked in order while the stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_hash_history_queue;

    localparam int DEPTH       = hhq_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int TAIL_CYCLES = 2 * DEPTH + 20;

    // Command code that the block leaves without effect.
    localparam logic [hhq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [hhq_pkg::KEY_W-1:0] ONES  = {hhq_pkg::KEY_W{1'b1}};
    localparam logic [hhq_pkg::KEY_W-1:0] ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [hhq_pkg::KEY_W-1:0] ALT_5 = 64'h5555_5555_5555_5555;
    localparam logic [hhq_pkg::KEY_W-1:0] KEY_P = 64'h0123_4567_89AB_CDEF;
    localparam logic [hhq_pkg::KEY_W-1:0] KEY_Q = 64'hFEDC_BA98_7654_3210;

    typedef struct {
        logic [hhq_pkg::CMD_W-1:0]   cmd;
        logic [hhq_pkg::KEY_W-1:0]   key;
        bit                          typed;
        logic                        found;
        logic [hhq_pkg::COUNT_W-1:0] count;
    } dir_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [hhq_pkg::KEY_W-1:0]       s_axis_tdata = '0;   // key
    logic [hhq_pkg::CMD_W-1:0]       s_axis_tuser = '0;   // command
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [hhq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // key_out, count, zero pad
    logic [0:0]                      m_axis_tuser;        // found
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [hhq_pkg::LIMIT_W-1:0]     cfg_data = '0;       // history_limit

    // Behavioral copy of the history, oldest entry at the front.
    logic [hhq_pkg::KEY_W-1:0]   history[$];
    logic [hhq_pkg::LIMIT_W-1:0] hist_limit = hhq_pkg::LIMIT_RESET;
    hhq_pkg::result_t            pending_results[$];
    logic [hhq_pkg::KEY_W-1:0]   key_pool[16];

    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    int error_count  = 0;
    int cycle_count  = 0;
    int cmd_count    = 0;
    int match_count  = 0;
    int peak_count   = 0;
    int limit_writes = 0;

    dir_row_t dir_rows[20];

    hash_history_queue #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one command to the history copy and returns what the block owes.
    function automatic hhq_pkg::result_t apply_command(
            input logic [hhq_pkg::CMD_W-1:0] cmd,
            input logic [hhq_pkg::KEY_W-1:0] key);
        hhq_pkg::result_t res;
        int               pos;
        pos = -1;
        res.found = 1'b0;
        res.key   = key;
        if (cmd == hhq_pkg::CMD_ADD)
        begin
            if (history.size() > hist_limit || history.size() >= DEPTH)
                history.delete(0);
            if (history.size() < DEPTH)
                history.insert(history.size(), key);
        end
        else if (cmd == hhq_pkg::CMD_REMOVE_ONE || cmd == hhq_pkg::CMD_REMOVE_THROUGH)
        begin
            for (int i = 0; i < history.size(); i++)
            begin
                if (pos < 0 && history[i] == key)
                    pos = i;
            end
            if (pos >= 0)
            begin
                res.found = 1'b1;
                match_count++;
                if (cmd == hhq_pkg::CMD_REMOVE_ONE)
                    history.delete(pos);
                else
                    repeat (pos + 1) history.delete(0);
            end
        end
        res.count = hhq_pkg::COUNT_W'(history.size());
        if (history.size() > peak_count)
            peak_count = history.size();
        return res;
    endfunction

    // Must be called right after a rising edge. A zero gap keeps tvalid high
    // so back-to-back transactions are possible.
    task automatic send_command(input logic [hhq_pkg::CMD_W-1:0] cmd,
                                input logic [hhq_pkg::KEY_W-1:0] key,
                                input bit typed, input logic exp_found,
                                input logic [hhq_pkg::COUNT_W-1:0] exp_count);
        int               gap;
        hhq_pkg::result_t res;
        gap = send_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        res = apply_command(cmd, key);
        if (typed)
        begin
            res.found = exp_found;
            res.key   = key;
            res.count = exp_count;
        end
        pending_results.insert(pending_results.size(), res);
        cmd_count++;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [hhq_pkg::LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        hist_limit = value;
        limit_writes++;
    endtask

    function automatic logic [hhq_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && history.size() > 0)
            return history[$urandom_range(0, history.size() - 1)];
        else if (r < 85)
            return key_pool[$urandom_range(0, 15)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [hhq_pkg::CMD_W-1:0] pick_command(input int add_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            return hhq_pkg::CMD_ADD;
        else if (r >= 96)
            return CMD_UNUSED;
        return r[0] ? hhq_pkg::CMD_REMOVE_THROUGH : hhq_pkg::CMD_REMOVE_ONE;
    endfunction

    // Output side: random stalls per transaction, none in some phases.
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = recv_idle_en ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        hhq_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result key %h", m_axis_tdata[63:0]));
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_axis_tuser[0] !== want.found)
                    report_mismatch($sformatf("found %b, expected %b (key %h)",
                                              m_axis_tuser[0], want.found, want.key));
                if (m_axis_tdata[63:0] !== want.key)
                    report_mismatch($sformatf("key_out %h, expected %h",
                                              m_axis_tdata[63:0], want.key));
                if (m_axis_tdata[70:64] !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d (key %h)",
                                              m_axis_tdata[70:64], want.count, want.key));
            end
        end
    end

    initial
    begin
        int phase_limits[PHASES];
        int add_pct;
        int lim;

        // Typed rows assume the reset limit of 63 and an empty store.
        dir_rows = '{
            '{hhq_pkg::CMD_REMOVE_ONE,     '0,    1'b1, 1'b0, 7'd0},
            '{hhq_pkg::CMD_REMOVE_THROUGH, ONES,  1'b1, 1'b0, 7'd0},
            '{CMD_UNUSED,                  ALT_5, 1'b1, 1'b0, 7'd0},
            '{hhq_pkg::CMD_ADD,            '0,    1'b1, 1'b0, 7'd1},
            '{hhq_pkg::CMD_ADD,            ONES,  1'b1, 1'b0, 7'd2},
            '{hhq_pkg::CMD_ADD,            ALT_A, 1'b1, 1'b0, 7'd3},
            '{hhq_pkg::CMD_ADD,            ALT_5, 1'b1, 1'b0, 7'd4},
            '{CMD_UNUSED,                  KEY_P, 1'b1, 1'b0, 7'd4},
            '{hhq_pkg::CMD_REMOVE_ONE,     KEY_P, 1'b1, 1'b0, 7'd4},
            '{hhq_pkg::CMD_REMOVE_ONE,     ONES,  1'b1, 1'b1, 7'd3},
            '{hhq_pkg::CMD_ADD,            '0,    1'b1, 1'b0, 7'd4},
            '{hhq_pkg::CMD_REMOVE_ONE,     '0,    1'b1, 1'b1, 7'd3},
            '{hhq_pkg::CMD_REMOVE_THROUGH, '0,    1'b1, 1'b1, 7'd0},
            '{hhq_pkg::CMD_ADD,            KEY_P, 1'b0, 1'b0, 7'd0},
            '{hhq_pkg::CMD_ADD,            KEY_Q, 1'b0, 1'b0, 7'd0},
            '{hhq_pkg::CMD_ADD,            KEY_P, 1'b0, 1'b0, 7'd0},
            '{hhq_pkg::CMD_REMOVE_THROUGH, KEY_P, 1'b0, 1'b0, 7'd0},
            '{hhq_pkg::CMD_REMOVE_THROUGH, KEY_Q, 1'b0, 1'b0, 7'd0},
            '{hhq_pkg::CMD_REMOVE_ONE,     KEY_P, 1'b0, 1'b0, 7'd0},
            '{hhq_pkg::CMD_REMOVE_THROUGH, '0,    1'b0, 1'b0, 7'd0}
        };
        // A negative entry means a random limit for that phase.
        phase_limits = '{0, 1, 63, -1, 2, 0, -1, 63};

        key_pool[0] = '0;
        key_pool[1] = ONES;
        for (int i = 2; i < 16; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_command(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed,
                         dir_rows[i].found, dir_rows[i].count);
        wait_all_results();

        // Fill past the depth so the count reaches 64 and adds start evicting.
        write_limit(hhq_pkg::LIMIT_RESET);
        send_idle_en = 1'b0;
        for (int i = 0; i < DEPTH + 4; i++)
            send_command(hhq_pkg::CMD_ADD,
                         (i % 3 == 0) ? key_pool[i % 16] : {$urandom, $urandom},
                         1'b0, 1'b0, '0);
        send_command(hhq_pkg::CMD_REMOVE_ONE, pick_key(), 1'b0, 1'b0, '0);
        send_command(hhq_pkg::CMD_REMOVE_THROUGH, pick_key(), 1'b0, 1'b0, '0);
        wait_all_results();

        for (int p = 0; p < PHASES; p++)
        begin
            lim = (phase_limits[p] < 0) ? $urandom_range(3, 62) : phase_limits[p];
            write_limit(hhq_pkg::LIMIT_W'(lim));
            send_idle_en = (p % 3 != 0);
            recv_idle_en = (p % 4 != 1);
            add_pct      = (p % 2 == 0) ? 70 : 50;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 59) == 0)
                    wait_all_results();
                send_command(pick_command(add_pct), pick_key(), 1'b0, 1'b0, '0);
            end
            wait_all_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d commands under %0d limit settings; %0d removes matched.",
                 cmd_count, limit_writes, match_count);
        $display("Peak occupancy %0d of %0d entries, %0d mismatches.",
                 peak_count, DEPTH, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
